// File: design/integer_field_formatter_defines.svh
// Assertion macros for the integer field formatter checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IFF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IFF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/iff_pkg.sv
// Shared types and constants of the integer field formatter.
// Used by the top level, the digit unit and the checker; depends on nothing.
package iff_pkg;

    localparam int MAX_WIDTH_DEF   = 63;
    localparam int DIGIT_SLOTS_DEF = 12;

    localparam logic [1:0] FUNC_SDEC = 2'd0;
    localparam logic [1:0] FUNC_UDEC = 2'd1;
    localparam logic [1:0] FUNC_HEX  = 2'd2;
    localparam logic [1:0] FUNC_CHAR = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UPA   = 8'h41;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  func;
        logic [5:0]  field_width;
        logic [1:0]  pad_mode;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [31:0] quot;
        logic [3:0]  rem;
    } t_div_res;

endpackage

// File: design/iff_digit_unit.sv
// Shared digit unit: splits one value into quotient and lowest digit, base 10 or 16.
// The result appears in the cycle after the value is presented; uses iff_pkg.
module iff_digit_unit (
    input  logic              i_clk,
    input  logic [31:0]       i_value,
    input  logic              i_hex,
    output iff_pkg::t_div_res o_res
);

    logic [63:0] w_prod;
    logic [28:0] r_q10;
    logic [31:0] r_value;
    logic        r_hex;
    logic [31:0] w_q10;
    logic [31:0] w_back;

    assign w_prod = i_value * iff_pkg::RECIP_10;

    always_ff @(posedge i_clk) begin
        r_q10   <= w_prod[63:iff_pkg::RECIP_SH];
        r_value <= i_value;
        r_hex   <= i_hex;
    end

    assign w_q10  = {3'b000, r_q10};
    assign w_back = r_value - ((w_q10 << 3) + (w_q10 << 1));

    always_comb begin
        if (r_hex) begin
            o_res.quot = {4'b0000, r_value[31:4]};
            o_res.rem  = r_value[3:0];
        end else begin
            o_res.quot = w_q10;
            o_res.rem  = w_back[3:0];
        end
    end

endmodule

// File: design/integer_field_formatter.sv
// Accept in S_IDLE, then S_MUL and S_REM per digit in the shared digit unit, setup in
// S_SIGN and S_PAD, then one character per cycle (up to 63) in S_EMIT as the sink takes
// them. Throughput: one item at a time; the next item is taken once the last character
// is loaded into the output register, or S_PAD finds none. Reset is synchronous and
// active low; it clears the sequencer and the output valid, not the digit store.
module integer_field_formatter #(
    parameter int MAX_WIDTH   = iff_pkg::MAX_WIDTH_DEF,
    parameter int DIGIT_SLOTS = iff_pkg::DIGIT_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  iff_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output iff_pkg::t_out o_data,
    input  logic          i_stall
);

    localparam int          CNT_W  = $clog2(DIGIT_SLOTS + 1);
    localparam int          IDX_W  = $clog2(DIGIT_SLOTS);
    localparam logic [5:0]  MAX_W  = 6'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(DIGIT_SLOTS);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_REM, S_SIGN, S_PAD, S_EMIT
    } t_state;

    t_state            r_state;
    logic [31:0]       r_u;
    logic              r_hex;
    logic              r_neg;
    logic [5:0]        r_w;
    logic [1:0]        r_pm;
    logic [CNT_W-1:0]  r_ndig;
    logic [5:0]        r_pad;
    logic [5:0]        r_left;
    logic              r_sign_first;
    logic [7:0]        r_store [DIGIT_SLOTS];
    logic              r_out_valid;
    iff_pkg::t_out     r_out;

    iff_pkg::t_div_res w_div;
    logic              w_out_free;
    logic [5:0]        w_wsat;
    logic              w_neg_in;
    logic [7:0]        w_digit;
    logic [7:0]        w_padch;
    logic              st_we;
    logic [IDX_W-1:0]  st_addr;
    logic [7:0]        st_data;
    logic [CNT_W-1:0]  w_ndig_m1;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [5:0]        w_ndig6;
    logic [5:0]        w_pad_calc;
    logic [5:0]        w_total;
    logic              w_sign_lead;

    iff_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_value (r_u),
        .i_hex   (r_hex),
        .o_res   (w_div)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_wsat   = (i_data.field_width > MAX_W) ? MAX_W : i_data.field_width;
    assign w_neg_in = (i_data.func == iff_pkg::FUNC_SDEC) && i_data.value[31];
    assign w_digit  = (w_div.rem < 4'd10) ? (iff_pkg::CHAR_ZERO + {4'b0000, w_div.rem})
                                          : (iff_pkg::CHAR_UPA + {4'b0000, w_div.rem}
                                             - iff_pkg::DIGIT_TEN);
    assign w_padch  = r_pm[1] ? iff_pkg::CHAR_ZERO : iff_pkg::CHAR_SPACE;

    assign w_ndig_m1   = r_ndig - ONE_C;
    assign w_rd_idx    = w_ndig_m1[IDX_W-1:0];
    assign w_ndig6     = 6'(r_ndig);
    assign w_pad_calc  = (r_w > w_ndig6) ? (r_w - w_ndig6) : 6'd0;
    assign w_total     = w_pad_calc + w_ndig6 + {5'b00000, r_sign_first};
    assign w_sign_lead = (r_w != 6'd0) && r_pm[1];

    always_comb begin
        st_we   = 1'b0;
        st_addr = r_ndig[IDX_W-1:0];
        st_data = iff_pkg::CHAR_MINUS;
        unique case (r_state)
            S_IDLE: begin
                st_addr = '0;
                if (i_valid) begin
                    if (i_data.func == iff_pkg::FUNC_CHAR) begin
                        st_we   = (i_data.value[7:0] != 8'd0);
                        st_data = i_data.value[7:0];
                    end else if (i_data.value == 32'd0) begin
                        st_we   = 1'b1;
                        st_data = iff_pkg::CHAR_ZERO;
                    end
                end
            end
            S_REM: begin
                st_we   = 1'b1;
                st_data = w_digit;
            end
            S_SIGN: begin
                st_we = r_neg && !w_sign_lead && (r_ndig < SLOTS_C);
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_addr] <= st_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_w          <= w_wsat;
                        r_pm         <= i_data.pad_mode;
                        r_hex        <= (i_data.func == iff_pkg::FUNC_HEX);
                        r_neg        <= w_neg_in;
                        r_sign_first <= 1'b0;
                        r_u          <= w_neg_in ? (32'd0 - i_data.value) : i_data.value;
                        if (i_data.func == iff_pkg::FUNC_CHAR) begin
                            r_ndig  <= (i_data.value[7:0] != 8'd0) ? ONE_C : '0;
                            r_state <= S_PAD;
                        end else if (i_data.value == 32'd0) begin
                            r_ndig  <= ONE_C;
                            r_state <= S_PAD;
                        end else begin
                            r_ndig  <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_ndig <= r_ndig + ONE_C;
                    r_u    <= w_div.quot;
                    if ((w_div.quot == 32'd0) || (r_ndig + ONE_C == SLOTS_C)) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_SIGN: begin
                    if (r_neg) begin
                        if (w_sign_lead) begin
                            r_sign_first <= 1'b1;
                            r_w          <= r_w - 6'd1;
                        end else if (r_ndig < SLOTS_C) begin
                            r_ndig <= r_ndig + ONE_C;
                        end
                    end
                    r_state <= S_PAD;
                end
                S_PAD: begin
                    r_pad  <= w_pad_calc;
                    r_left <= w_total;
                    if (w_total == 6'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out.last  <= (r_left == 6'd1);
                        r_left      <= r_left - 6'd1;
                        priority if (r_sign_first) begin
                            r_out.out_char <= iff_pkg::CHAR_MINUS;
                            r_sign_first   <= 1'b0;
                        end else if (!r_pm[0] && (r_pad != 6'd0)) begin
                            r_out.out_char <= w_padch;
                            r_pad          <= r_pad - 6'd1;
                        end else if (r_ndig != '0) begin
                            r_out.out_char <= r_store[w_rd_idx];
                            r_ndig         <= w_ndig_m1;
                        end else begin
                            r_out.out_char <= w_padch;
                            r_pad          <= r_pad - 6'd1;
                        end
                        if (r_left == 6'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/iff_checker.sv
// Port-level checker for the integer field formatter, bound to the top level.
// Depends on iff_pkg and the macros in integer_field_formatter_defines.svh.
`include "integer_field_formatter_defines.svh"

module iff_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input iff_pkg::t_in  i_data,
    input logic          o_stall,
    input logic          o_valid,
    input iff_pkg::t_out o_data,
    input logic          i_stall
);

    `IFF_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "stalled output changed")
    `IFF_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "input not blocked after a transfer")
    `IFF_ASSERT_IMP(a_idle_holds_last, o_valid && !o_stall, o_data.last, "idle block shows a non-final character")
    `IFF_ASSERT_NXT(a_no_early_char, i_valid && !o_stall, !o_valid || o_data.last, "character emitted too early")

endmodule

bind integer_field_formatter iff_checker u_iff_checker (.*);
